/* hw/rtl/sha1_message_hasher_defines.svh */
// assertion macros for the sha-1 message hasher
`ifndef SHA1_MESSAGE_HASHER_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge outside reset
`define SHA1_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SHA1_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/sha1mh_pkg.sv */
// shared types, constants and round functions of the sha-1 message hasher
package sha1mh_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned FillW      = 7;   // holds 0..64
  localparam int unsigned TotalW     = 61;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned RoundW     = 7;
  localparam int unsigned HashWords  = 5;
  localparam int unsigned WinWords   = 16;

  localparam logic [RoundW-1:0] LastRound = RoundW'(Rounds - 1);
  localparam logic [FillW-1:0]  LenFill   = FillW'(BlockBytes - 8);
  localparam logic [2:0]        LastWord  = 3'd4;
  localparam logic [2:0]        LastLen   = 3'd7;
  localparam logic [7:0]        PadMark   = 8'h80;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] HInit [HashWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [2:0] {
    ST_ABSORB,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  typedef enum logic [1:0] {
    STG_CH,
    STG_PAR1,
    STG_MAJ,
    STG_PAR2
  } stage_e;

  typedef struct packed {
    logic      shift;      // push one byte into the block buffer
    byte_sel_e byte_sel;
    logic [2:0] len_idx;   // length byte, most significant first
    logic      count;      // bump the message byte count
    logic      set_ovf;
    logic      start;      // hand the full block to the round engine
    logic      clear;      // back to the initial state for a new message
    logic [2:0] word_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic at_len;
    logic busy;
    logic total_max;
    logic ovf;
  } dp_sts_t;

  function automatic logic [31:0] round_f(stage_e stg, logic [31:0] b, logic [31:0] c,
                                          logic [31:0] d);
    logic [31:0] f;
    unique case (stg)
      STG_CH:  f = (b & c) | (~b & d);
      STG_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] round_k(stage_e stg);
    logic [31:0] k;
    unique case (stg)
      STG_CH:   k = K0;
      STG_PAR1: k = K1;
      STG_MAJ:  k = K2;
      default:  k = K3;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sha1mh_datapath.sv */
// block buffer, byte count, chaining words and round engine
module sha1mh_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  sha1mh_pkg::dp_cmd_t cmd_i,
  output sha1mh_pkg::dp_sts_t sts_o,
  output logic [31:0]         digest_word_o,
  output logic                length_overflow_o
);

  logic [7:0]  blk_q [sha1mh_pkg::BlockBytes];
  logic [sha1mh_pkg::FillW-1:0]  fill_q;
  logic [sha1mh_pkg::TotalW-1:0] total_q;
  logic        ovf_q;
  logic [31:0] h_q  [sha1mh_pkg::HashWords];
  logic [31:0] wk_q [sha1mh_pkg::HashWords];
  logic [31:0] w_q  [sha1mh_pkg::WinWords];
  logic [sha1mh_pkg::RoundW-1:0] rnd_q;
  logic        busy_q;
  logic        fin_q;

  logic [63:0] len_bits;
  logic [7:0]  shift_byte;
  sha1mh_pkg::stage_e stg;
  logic [31:0] t_sum;
  logic [31:0] w_mix;
  logic [31:0] w_new;

  assign len_bits = {total_q, 3'b000};

  always_comb begin
    unique case (cmd_i.byte_sel)
      sha1mh_pkg::SEL_DATA: shift_byte = data_byte_i;
      sha1mh_pkg::SEL_MARK: shift_byte = sha1mh_pkg::PadMark;
      sha1mh_pkg::SEL_ZERO: shift_byte = 8'h00;
      default:              shift_byte = len_bits[{3'd7 - cmd_i.len_idx, 3'b000} +: 8];
    endcase
  end

  // byte shift line, first byte of the block ends up at the top
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int i = sha1mh_pkg::BlockBytes - 1; i > 0; i--) begin
        blk_q[i] <= blk_q[i-1];
      end
      blk_q[0] <= shift_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.clear) begin
      fill_q  <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        fill_q <= '0;
      end else if (cmd_i.shift) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.count) begin
        total_q <= total_q + 1'b1;
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // round logic
  always_comb begin
    if (rnd_q < sha1mh_pkg::RoundW'(20)) begin
      stg = sha1mh_pkg::STG_CH;
    end else if (rnd_q < sha1mh_pkg::RoundW'(40)) begin
      stg = sha1mh_pkg::STG_PAR1;
    end else if (rnd_q < sha1mh_pkg::RoundW'(60)) begin
      stg = sha1mh_pkg::STG_MAJ;
    end else begin
      stg = sha1mh_pkg::STG_PAR2;
    end
  end

  assign t_sum = {wk_q[0][26:0], wk_q[0][31:27]}
               + sha1mh_pkg::round_f(stg, wk_q[1], wk_q[2], wk_q[3])
               + wk_q[4] + sha1mh_pkg::round_k(stg) + w_q[0];
  assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
    end else if (busy_q) begin
      if (fin_q) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
      end else if (rnd_q == sha1mh_pkg::LastRound) begin
        fin_q <= 1'b1;
      end else begin
        rnd_q <= rnd_q + 1'b1;
      end
    end
  end

  // schedule window and working words
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int k = 0; k < sha1mh_pkg::WinWords; k++) begin
        w_q[k] <= {blk_q[63-4*k], blk_q[62-4*k], blk_q[61-4*k], blk_q[60-4*k]};
      end
      for (int k = 0; k < sha1mh_pkg::HashWords; k++) begin
        wk_q[k] <= h_q[k];
      end
    end else if (busy_q && !fin_q) begin
      for (int k = 0; k < sha1mh_pkg::WinWords - 1; k++) begin
        w_q[k] <= w_q[k+1];
      end
      w_q[sha1mh_pkg::WinWords-1] <= w_new;
      wk_q[4] <= wk_q[3];
      wk_q[3] <= wk_q[2];
      wk_q[2] <= {wk_q[1][1:0], wk_q[1][31:2]};
      wk_q[1] <= wk_q[0];
      wk_q[0] <= t_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sha1mh_pkg::HashWords; k++) begin
        h_q[k] <= sha1mh_pkg::HInit[k];
      end
    end else if (cmd_i.clear) begin
      for (int k = 0; k < sha1mh_pkg::HashWords; k++) begin
        h_q[k] <= sha1mh_pkg::HInit[k];
      end
    end else if (busy_q && fin_q) begin
      for (int k = 0; k < sha1mh_pkg::HashWords; k++) begin
        h_q[k] <= h_q[k] + wk_q[k];
      end
    end
  end

  always_comb begin
    unique case (cmd_i.word_sel)
      3'd0:    digest_word_o = h_q[0];
      3'd1:    digest_word_o = h_q[1];
      3'd2:    digest_word_o = h_q[2];
      3'd3:    digest_word_o = h_q[3];
      3'd4:    digest_word_o = h_q[4];
      default: digest_word_o = '0;
    endcase
    if (ovf_q) begin
      digest_word_o = '0;
    end
  end

  assign length_overflow_o = ovf_q;

  assign sts_o.full      = fill_q[sha1mh_pkg::FillW-1];
  assign sts_o.at_len    = (fill_q == sha1mh_pkg::LenFill);
  assign sts_o.busy      = busy_q;
  assign sts_o.total_max = &total_q;
  assign sts_o.ovf       = ovf_q;

endmodule

/* hw/rtl/sha1mh_ctrl.sv */
// message controller: absorb, padding, drain and digest output
module sha1mh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                byte_present_i,
  input  logic                message_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          word_number_o,
  output logic                last_word_o,
  output sha1mh_pkg::dp_cmd_t cmd_o,
  input  sha1mh_pkg::dp_sts_t sts_i
);

  sha1mh_pkg::state_e state_q, state_d;
  logic [2:0] len_q, len_d;
  logic [2:0] word_q, word_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1mh_pkg::ST_ABSORB;
      len_q   <= '0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      word_q  <= word_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    len_d          = len_q;
    word_d         = word_q;
    cmd_o          = '0;
    cmd_o.byte_sel = sha1mh_pkg::SEL_DATA;
    cmd_o.len_idx  = len_q;
    cmd_o.word_sel = word_q;
    cmd_o.start    = sts_i.full && !sts_i.busy;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;

    unique case (state_q)
      sha1mh_pkg::ST_ABSORB: begin
        in_ready_o = !sts_i.full;
        if (in_valid_i && !sts_i.full) begin
          if (byte_present_i && !sts_i.ovf) begin
            if (sts_i.total_max) begin
              cmd_o.set_ovf = 1'b1;
            end else begin
              cmd_o.shift = 1'b1;
              cmd_o.count = 1'b1;
            end
          end
          if (message_end_i) begin
            if (sts_i.ovf || (byte_present_i && sts_i.total_max)) begin
              state_d = sha1mh_pkg::ST_DRAIN;
            end else begin
              state_d = sha1mh_pkg::ST_PAD_MARK;
            end
          end
        end
      end
      sha1mh_pkg::ST_PAD_MARK: begin
        if (!sts_i.full) begin
          cmd_o.shift    = 1'b1;
          cmd_o.byte_sel = sha1mh_pkg::SEL_MARK;
          state_d        = sha1mh_pkg::ST_PAD_ZERO;
        end
      end
      sha1mh_pkg::ST_PAD_ZERO: begin
        if (sts_i.at_len) begin
          len_d   = '0;
          state_d = sha1mh_pkg::ST_PAD_LEN;
        end else if (!sts_i.full) begin
          cmd_o.shift    = 1'b1;
          cmd_o.byte_sel = sha1mh_pkg::SEL_ZERO;
        end
      end
      sha1mh_pkg::ST_PAD_LEN: begin
        if (!sts_i.full) begin
          cmd_o.shift    = 1'b1;
          cmd_o.byte_sel = sha1mh_pkg::SEL_LEN;
          len_d          = len_q + 1'b1;
          if (len_q == sha1mh_pkg::LastLen) begin
            state_d = sha1mh_pkg::ST_DRAIN;
          end
        end
      end
      sha1mh_pkg::ST_DRAIN: begin
        if (!sts_i.busy && !sts_i.full) begin
          word_d  = '0;
          state_d = sha1mh_pkg::ST_EMIT;
        end
      end
      sha1mh_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (word_q == sha1mh_pkg::LastWord) begin
            cmd_o.clear = 1'b1;
            word_d      = '0;
            state_d     = sha1mh_pkg::ST_ABSORB;
          end else begin
            word_d = word_q + 1'b1;
          end
        end
      end
      default: state_d = sha1mh_pkg::ST_ABSORB;
    endcase
  end

  assign word_number_o = word_q;
  assign last_word_o   = (state_q == sha1mh_pkg::ST_EMIT) && (word_q == sha1mh_pkg::LastWord);

endmodule

/* hw/rtl/sha1_message_hasher.sv */
// sha-1 message hasher top level: controller plus datapath
// usage:
//   input channel (in_valid_i / in_ready_o) takes one transfer per message byte;
//   byte_present_i marks a real byte, message_end_i closes the message (a byte in
//   the same transfer is its last byte)
//   output channel (out_valid_o / out_ready_i) gives five transfers per message,
//   digest words 0..4, last_word_o on word 4, length_overflow_o with zero words
//   when the byte count ran past 2^61-1
// throughput: one byte per cycle into a 64-byte shift buffer while it is not full;
//   a full block moves to the round engine (80 rounds, one chaining add) as soon
//   as the engine is idle, and the buffer fills with the next block meanwhile, so
//   a stream of blocks is limited by the round engine, the input stalling on a full buffer
// after the end transfer: padding shifts one byte per cycle to the block end while
//   the buffer is not full (through an extra block when the length does not fit),
//   then the length field; the last block then passes handoff, the 80 rounds, the
//   chaining add and a state change before word 0, later while the engine is still busy;
//   words follow one per cycle while out_ready_i is high
// no input transfer is taken during padding or while the digest is read out
// a stalled receiver simply holds the current word; nothing is lost
// reset: chaining words to initial values, count and overflow clear, buffer unset
module sha1_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        last_word_o,
  output logic        length_overflow_o
);

`include "sha1_message_hasher_defines.svh"

  // command and status between controller and datapath
  sha1mh_pkg::dp_cmd_t dp_cmd;
  sha1mh_pkg::dp_sts_t dp_sts;

  sha1mh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .word_number_o  (word_number_o),
    .last_word_o    (last_word_o),
    .cmd_o          (dp_cmd),
    .sts_i          (dp_sts)
  );

  // block buffer, count, chaining words and round engine
  sha1mh_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .data_byte_i       (data_byte_i),
    .cmd_i             (dp_cmd),
    .sts_o             (dp_sts),
    .digest_word_o     (digest_word_o),
    .length_overflow_o (length_overflow_o)
  );

  // the two channels never open together
  `SHA1_ASSERT_SAME(a_one_side, clk_i, rst_ni, in_ready_o, !out_valid_o, "input and output open together")
  // digest words are only shown once the round engine has settled
  `SHA1_ASSERT_SAME(a_emit_idle, clk_i, rst_ni, out_valid_o, !dp_sts.busy, "digest shown while engine busy")
  // a block handoff empties the buffer and occupies the engine
  `SHA1_ASSERT_NEXT(a_start, clk_i, rst_ni, dp_cmd.start, dp_sts.busy && !dp_sts.full, "block handoff failed")
  // after the last digest word the block is ready for a new message at once
  `SHA1_ASSERT_NEXT(a_restart, clk_i, rst_ni, out_valid_o && out_ready_i && last_word_o, in_ready_o, "no restart after digest")

endmodule

/* sim/sha1_digest_checker.sv */
// sha-1 digest checker: watches both channels, predicts the digest words and compares
`timescale 1ns / 100ps

module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_number_i,
  input  logic        last_word_i,
  input  logic        length_overflow_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [31:0] value;
    logic [2:0]  number;
    logic        last;
    logic        overflow;
  } digest_item_t;

  logic [31:0]                   chain_h [sha1mh_pkg::HashWords];
  logic [7:0]                    blk     [sha1mh_pkg::BlockBytes];
  logic [sha1mh_pkg::TotalW-1:0] msg_bytes;
  logic                          len_ovf;
  digest_item_t                  digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic restart_message();
    int k;
    for (k = 0; k < sha1mh_pkg::HashWords; k++) chain_h[k] = sha1mh_pkg::HInit[k];
    msg_bytes = '0;
    len_ovf   = 1'b0;
  endtask

  task automatic compress_block();
    logic [31:0] w [sha1mh_pkg::WinWords];
    logic [31:0] a, b, c, d, e, f, kc, t, x;
    int r, k;
    for (k = 0; k < sha1mh_pkg::WinWords; k++)
      w[k] = {blk[4*k], blk[4*k+1], blk[4*k+2], blk[4*k+3]};
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (r = 0; r < sha1mh_pkg::Rounds; r++) begin
      if (r >= 16) begin
        x = w[(r+13) & 15] ^ w[(r+8) & 15] ^ w[(r+2) & 15] ^ w[r & 15];
        w[r & 15] = rol(x, 1);
      end
      x = w[r & 15];
      if (r < 20) begin
        f = (b & c) | (~b & d);
        kc = sha1mh_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        kc = sha1mh_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        kc = sha1mh_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        kc = sha1mh_pkg::K3;
      end
      t = rol(a, 5) + f + e + kc + x;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endtask

  // absorb one input transfer; an end mark pads, finishes and queues five words
  task automatic hash_item(input logic [7:0] b, input logic p, input logic e);
    int pos, k;
    logic [63:0] bit_len;
    digest_item_t item;
    if (p && !len_ovf) begin
      if (msg_bytes == '1) begin
        len_ovf = 1'b1;
      end else begin
        pos = int'(msg_bytes[5:0]);
        blk[pos] = b;
        msg_bytes++;
        if (pos == sha1mh_pkg::BlockBytes - 1) compress_block();
      end
    end
    if (e) begin
      if (!len_ovf) begin
        bit_len = {msg_bytes, 3'b000};
        pos = int'(msg_bytes[5:0]);
        blk[pos] = sha1mh_pkg::PadMark;
        pos++;
        // length does not fit behind the mark: one extra block
        if (pos > 56) begin
          while (pos < sha1mh_pkg::BlockBytes) begin
            blk[pos] = 8'h00;
            pos++;
          end
          compress_block();
          pos = 0;
        end
        while (pos < 56) begin
          blk[pos] = 8'h00;
          pos++;
        end
        for (k = 0; k < 8; k++) blk[56+k] = bit_len[63-8*k -: 8];
        compress_block();
      end
      for (k = 0; k < sha1mh_pkg::HashWords; k++) begin
        item.value    = len_ovf ? 32'h0 : chain_h[k];
        item.number   = 3'(k);
        item.last     = (3'(k) == sha1mh_pkg::LastWord);
        item.overflow = len_ovf;
        digest_q.push_back(item);
      end
      restart_message();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    fail_count_o++;
  endtask

  task automatic check_digest_word();
    digest_item_t want;
    if (digest_q.size() == 0) begin
      report_mismatch("digest word with nothing pending", digest_word_i, 32'h0);
      return;
    end
    want = digest_q.pop_front();
    if (digest_word_i !== want.value)
      report_mismatch("digest_word", digest_word_i, want.value);
    if (word_number_i !== want.number)
      report_mismatch("word_number", 32'(word_number_i), 32'(want.number));
    if (last_word_i !== want.last)
      report_mismatch("last_word", 32'(last_word_i), 32'(want.last));
    if (length_overflow_i !== want.overflow)
      report_mismatch("length_overflow", 32'(length_overflow_i), 32'(want.overflow));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      digest_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) hash_item(data_byte_i, byte_present_i, message_end_i);
      if (out_valid_i && out_ready_i) check_digest_word();
      pending_o = digest_q.size();
    end
  end

endmodule

/* sim/tb.sv */
// testbench top for the sha-1 message hasher: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb;

  // receiver behavior, switched at random intervals
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_SPARSE
  } rx_mode_e;

  localparam int unsigned RandomItems  = 470;
  localparam int unsigned HoldMessage  = 6;    // long receiver hold-off after this message
  localparam int unsigned HoldCycles   = 500;
  localparam int unsigned PauseMessage = 10;   // sender waits for a drained block here
  localparam int unsigned TailCycles   = 300;  // quiet tail after the last digest word

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        message_end;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;
  logic        length_overflow;

  int fail_count;
  int pending;
  int items_sent;
  int msg_count;
  int burst_left;
  bit rx_hold;

  sha1_message_hasher i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (data_byte),
    .byte_present_i    (byte_present),
    .message_end_i     (message_end),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .digest_word_o     (digest_word),
    .word_number_o     (word_number),
    .last_word_o       (last_word),
    .length_overflow_o (length_overflow)
  );

  sha1_digest_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .data_byte_i       (data_byte),
    .byte_present_i    (byte_present),
    .message_end_i     (message_end),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .digest_word_i     (digest_word),
    .word_number_i     (word_number),
    .last_word_i       (last_word),
    .length_overflow_i (length_overflow),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one transfer at the falling edge and hold it until accepted;
  // at the end of a burst valid may drop for a random gap
  task automatic offer(input logic [7:0] b, input logic p, input logic e);
    int gap;
    @(negedge clk);
    in_valid     = 1'b1;
    data_byte    = b;
    byte_present = p;
    message_end  = e;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      // mostly short gaps, now and then a long one, sometimes none at all
      if ($urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 3);
      if (gap > 0) begin
        @(negedge clk);
        in_valid     = 1'b0;
        // junk payload while idle, it must be ignored
        data_byte    = 8'($urandom);
        byte_present = 1'($urandom);
        message_end  = 1'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // one message of len bytes; the end mark rides on the last byte or on its own transfer
  task automatic send_message(input int len, input bit end_on_byte);
    int i;
    for (i = 0; i < len; i++) begin
      // transfer with neither byte nor end, scattered in
      if ($urandom_range(0, 11) == 0) offer(8'($urandom), 1'b0, 1'b0);
      offer(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) offer(8'($urandom), 1'b0, 1'b1);
    msg_count++;
  endtask

  // stop offering until every queued digest word has been read out
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: ready pattern of its own, forced low during the hold-off
  initial begin
    rx_mode_e rx_mode;
    int       rx_left;
    rx_mode   = RX_OPEN;
    rx_left   = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(5, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_ready = 1'b1;
        RX_COIN:   out_ready = 1'($urandom);
        RX_MOSTLY: out_ready = ($urandom_range(0, 7) != 0);
        default:   out_ready = ($urandom_range(0, 3) == 0);
      endcase
      if (rx_hold) out_ready = 1'b0;
    end
  end

  // long receiver hold-off once a digest is up, while the sender keeps offering;
  // the block takes no transfer during read-out, so its input stalls
  initial begin
    rx_hold = 1'b0;
    while (msg_count < HoldMessage) @(negedge clk);
    do @(posedge clk); while (!out_valid);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold = 1'b0;
  end

  // timeout
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int  len;
    int  pick;
    in_valid     = 1'b0;
    data_byte    = 8'h00;
    byte_present = 1'b0;
    message_end  = 1'b0;
    items_sent   = 0;
    msg_count    = 0;
    burst_left   = 0;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty message: end mark alone
    offer(8'h00, 1'b0, 1'b1);
    msg_count++;
    // "abc" with the end mark on a transfer of its own
    offer(8'h61, 1'b1, 1'b0);
    offer(8'h62, 1'b1, 1'b0);
    offer(8'h63, 1'b1, 1'b0);
    offer(8'hFF, 1'b0, 1'b1);
    msg_count++;
    // single byte together with the end mark
    offer(8'hFF, 1'b1, 1'b1);
    msg_count++;
    // zero bytes around a transfer that carries nothing
    offer(8'h00, 1'b1, 1'b0);
    offer(8'hFF, 1'b0, 1'b0);
    offer(8'h00, 1'b1, 1'b1);
    msg_count++;
    wait_drained();

    items_sent = 0;
    while (items_sent < RandomItems) begin
      pick = $urandom_range(0, 9);
      // mostly short messages, some on the padding boundaries, a few longer
      if (pick <= 5) begin
        len = $urandom_range(0, 20);
      end else if (pick <= 7) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else if (pick == 8) begin
        len = $urandom_range(0, 3);
      end else begin
        len = $urandom_range(60, 130);
      end
      // last message trimmed to the remaining item budget
      if (len > int'(RandomItems) - items_sent) len = int'(RandomItems) - items_sent;
      send_message(len, 1'($urandom));
      if (msg_count == PauseMessage) wait_drained();
    end

    // all offered; wait for the last digest and a quiet tail
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sha1mh_pkg.sv
hw/rtl/sha1mh_datapath.sv
hw/rtl/sha1mh_ctrl.sv
hw/rtl/sha1_message_hasher.sv
sim/sha1_digest_checker.sv
sim/tb.sv
